// File: hdl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD = 3'd0,
        MODE_INS_TAIL = 3'd1,
        MODE_INS_POS  = 3'd2,
        MODE_DEL_HEAD = 3'd3,
        MODE_DEL_TAIL = 3'd4,
        MODE_DEL_POS  = 3'd5,
        MODE_SEARCH   = 3'd6
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] entry_count;
    } t_result;

endpackage

// File: hdl/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values: positional insert, delete
// and search, one result per command.
// ----------------------------------------------------------------------------
// Commands: one at a time, the next taken the cycle after its result is
//   registered; the walk over the store goes one entry per cycle through the
//   single read port.
// Reset: synchronous, active low; the list is empty, store contents undefined.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ple_pkg::MODE_W-1:0] i_mode,
    input  logic signed [31:0]         i_value,
    input  logic [ple_pkg::POS_W-1:0]  i_position,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ple_pkg::STAT_W-1:0] o_status,
    output logic [ple_pkg::POS_W-1:0]  o_found_position,
    output logic [ple_pkg::POS_W-1:0]  o_entry_count
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic             busy, res_valid, res_ready;
    t_result          res;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [VAL_W-1:0] mem_wdata, mem_rdata;
    logic             r_out_valid;
    t_result          r_out;

    ple_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_valid && !o_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ple_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_stall          = busy;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found_position;
    assign o_entry_count    = r_out.entry_count;

endmodule

// File: hdl/ple_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ple_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ple_pkg::VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [ple_pkg::VAL_W-1:0] o_rdata
);
    import ple_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ple_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_seq
// Command sequencer: checks, walks the store one entry a cycle to shift or
// search, and keeps the entry count.
// ----------------------------------------------------------------------------
module ple_seq #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ple_pkg::MODE_W-1:0] i_mode,
    input  logic [ple_pkg::VAL_W-1:0]  i_value,
    input  logic [ple_pkg::POS_W-1:0]  i_position,
    output logic                       o_busy,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output ple_pkg::t_result           o_res,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [ple_pkg::VAL_W-1:0]  o_mem_wdata,
    output logic [AW-1:0]              o_mem_raddr,
    input  logic [ple_pkg::VAL_W-1:0]  i_mem_rdata
);
    import ple_pkg::*;

    localparam int MW = (CW > POS_W) ? CW : POS_W;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_last, n_last;
    logic [CW-1:0]    r_at, n_at;
    logic [CW-1:0]    r_waddr, n_waddr;
    logic [CW-1:0]    r_found, n_found;
    logic             r_issue, n_issue;
    logic             r_pend, n_pend;
    logic             r_ins, n_ins;
    logic             r_inc, n_inc;
    logic             r_dec, n_dec;
    logic [VAL_W-1:0] r_key, n_key;
    t_status          r_status, n_status;

    logic          full, empty;
    logic [MW-1:0] pos_m, cnt_m, at_m, found_m, cnt_out_m;
    logic [CW-1:0] at_c;
    logic          go_ins, go_del, bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
            r_inc   <= 1'b0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_inc   <= n_inc;
            r_dec   <= n_dec;
        end
        r_idx    <= n_idx;
        r_last   <= n_last;
        r_at     <= n_at;
        r_waddr  <= n_waddr;
        r_found  <= n_found;
        r_ins    <= n_ins;
        r_key    <= n_key;
        r_status <= n_status;
    end

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);
    assign pos_m = MW'(i_position);
    assign cnt_m = MW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_last      = r_last;
        n_at        = r_at;
        n_waddr     = r_waddr;
        n_found     = r_found;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_ins       = r_ins;
        n_inc       = r_inc;
        n_dec       = r_dec;
        n_key       = r_key;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_waddr[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx[AW-1:0];
        o_res_valid = 1'b0;
        go_ins      = 1'b0;
        go_del      = 1'b0;
        bad         = 1'b0;
        at_m        = '0;
        at_c        = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_key    = i_value;
                    n_found  = '0;
                    n_inc    = 1'b0;
                    n_dec    = 1'b0;
                    n_status = STAT_OK;
                    n_state  = ST_FINISH;
                    case (t_mode'(i_mode))
                        MODE_INS_HEAD: begin
                            at_m = '0;
                            if (full) n_status = STAT_FULL;
                            else      go_ins   = 1'b1;
                        end
                        MODE_INS_TAIL: begin
                            at_m = cnt_m;
                            if (full) n_status = STAT_FULL;
                            else      go_ins   = 1'b1;
                        end
                        MODE_INS_POS: begin
                            at_m = pos_m - MW'(1);
                            bad  = (pos_m == '0) || (pos_m > cnt_m + MW'(1));
                            if (full)     n_status = STAT_FULL;
                            else if (bad) n_status = STAT_BADPOS;
                            else          go_ins   = 1'b1;
                        end
                        MODE_DEL_HEAD: begin
                            at_m = '0;
                            if (empty) n_status = STAT_EMPTY;
                            else       go_del   = 1'b1;
                        end
                        MODE_DEL_TAIL: begin
                            at_m = cnt_m - MW'(1);
                            if (empty) n_status = STAT_EMPTY;
                            else       go_del   = 1'b1;
                        end
                        MODE_DEL_POS: begin
                            at_m = pos_m - MW'(1);
                            bad  = (pos_m == '0) || (pos_m > cnt_m);
                            if (empty)    n_status = STAT_EMPTY;
                            else if (bad) n_status = STAT_BADPOS;
                            else          go_del   = 1'b1;
                        end
                        MODE_SEARCH: begin
                            n_status = STAT_NOTFOUND;
                            n_idx    = '0;
                            n_last   = r_count - CW'(1);
                            n_issue  = !empty;
                            n_pend   = 1'b0;
                            n_state  = ST_SEARCH;
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                    at_c = at_m[CW-1:0];
                    n_at = at_c;
                    if (go_ins) begin
                        n_ins   = 1'b1;
                        n_inc   = 1'b1;
                        n_idx   = r_count - CW'(1);
                        n_last  = at_c;
                        n_issue = (at_c < r_count);
                        n_pend  = 1'b0;
                        n_state = ST_SHIFT;
                    end
                    if (go_del) begin
                        n_ins   = 1'b0;
                        n_dec   = 1'b1;
                        n_idx   = at_c + CW'(1);
                        n_last  = r_count - CW'(1);
                        n_issue = (at_c + CW'(1) < r_count);
                        n_pend  = 1'b0;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                // read one ahead, write the previous read one place over
                o_mem_we = r_pend;
                if (r_issue) begin
                    n_pend  = 1'b1;
                    n_waddr = r_ins ? r_idx + CW'(1) : r_idx - CW'(1);
                    if (r_idx == r_last) n_issue = 1'b0;
                    else n_idx = r_ins ? r_idx - CW'(1) : r_idx + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_ins ? ST_PUT : ST_FINISH;
                end
            end
            ST_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_at[AW-1:0];
                o_mem_wdata = r_key;
                n_state     = ST_FINISH;
            end
            ST_SEARCH: begin
                if (r_pend && (i_mem_rdata == r_key)) begin
                    n_found  = r_waddr + CW'(1);
                    n_status = STAT_OK;
                    n_pend   = 1'b0;
                    n_issue  = 1'b0;
                    n_state  = ST_FINISH;
                end else if (r_issue) begin
                    n_pend  = 1'b1;
                    n_waddr = r_idx;
                    if (r_idx == r_last) n_issue = 1'b0;
                    else n_idx = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_inc) n_count = r_count + CW'(1);
                    if (r_dec) n_count = r_count - CW'(1);
                    n_inc   = 1'b0;
                    n_dec   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign found_m   = MW'(r_found);
    assign cnt_out_m = MW'(r_inc ? r_count + CW'(1) : (r_dec ? r_count - CW'(1) : r_count));

    assign o_busy                = (r_state != ST_IDLE);
    assign o_res.status          = r_status;
    assign o_res.found_position  = found_m[POS_W-1:0];
    assign o_res.entry_count     = cnt_out_m[POS_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_grow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && r_inc) |-> (r_count != CW'(CAPACITY)))
        else $error("insert completed on a full store");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && r_pend) |-> (r_waddr < CW'(CAPACITY)))
        else $error("shift write outside the store");

    a_put_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT) |-> (r_at <= r_count && r_inc))
        else $error("insert slot beyond the tail");

    a_search_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_status == STAT_OK && r_found != '0)
            |-> (r_found <= r_count))
        else $error("found position beyond the list");

endmodule
